[hdl/ecu_pkg.sv]
`timescale 1ns / 1ps

package ecu_pkg;

  localparam int FUNC_W = 4;
  localparam int DATA_W = 18;
  localparam int ENTRY_W = 31;
  localparam int FIELD_MAX = 131071;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam func_t FN_SMOOTH     = 4'd0;
  localparam func_t FN_INOUTQUAD  = 4'd1;
  localparam func_t FN_INOUTSINE  = 4'd2;
  localparam func_t FN_OUTEXPO    = 4'd3;
  localparam func_t FN_INOUTEXPO  = 4'd4;
  localparam func_t FN_INOUTCUBIC = 4'd5;
  localparam func_t FN_OUTCUBIC   = 4'd6;
  localparam func_t FN_OUTQUINT   = 4'd7;
  localparam func_t FN_OUTQUAD    = 4'd8;
  localparam func_t FN_LINEAR     = 4'd9;
  localparam func_t FN_INOUTQUINT = 4'd10;

  localparam logic [63:0] Q30 = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  // Per-request control that travels beside the clamped progress value
  typedef struct packed {
    func_t func;
    logic  lo;      // t below one half
    logic  le;      // t at or below one half
    logic  t_zero;
    logic  t_one;
  } curve_ctrl_t;

  // Unsigned quotient by shift and subtract; only ever evaluated to build constant tables
  function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    int b;
    q = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos(x) in Q30, x in Q30, by a fifteen-term series
  function automatic logic [ENTRY_W-1:0] cos_series(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] dd;
    logic signed [63:0] sum;
    int k;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = Q30;
    sum = $signed(Q30);
    for (k = 1; k <= 14; k++) begin
      dd = 64'((2 * k - 1) * (2 * k));
      term = quot64(((term * x2 + (64'd1 << 29)) >> 30) + (dd >> 1), dd);
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(Q30)) sum = $signed(Q30);
    return ENTRY_W'(sum);
  endfunction

  // exp(-y) in Q30, y in Q30, by a seventeen-term series
  function automatic logic [ENTRY_W-1:0] expneg_series(input logic [63:0] y);
    logic [63:0] term;
    logic [63:0] kk;
    logic signed [63:0] sum;
    int k;
    term = Q30;
    sum = $signed(Q30);
    for (k = 1; k <= 16; k++) begin
      kk = 64'(k);
      term = quot64(((term * y + (64'd1 << 29)) >> 30) + (kk >> 1), kk);
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(Q30)) sum = $signed(Q30);
    return ENTRY_W'(sum);
  endfunction

endpackage

[hdl/ecu_poly.sv]
`timescale 1ns / 1ps

module ecu_poly #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  ecu_pkg::curve_ctrl_t        ctl,
  input  logic [FRAC_BITS:0]          t,
  input  logic [FRAC_BITS:0]          d,
  output logic signed [FRAC_BITS+7:0] r
);
  import ecu_pkg::*;

  localparam int OW = FRAC_BITS + 3;
  localparam int PW = 2 * OW;
  localparam int RW = FRAC_BITS + 8;
  localparam logic [OW-1:0] TWO_O   = OW'(64'd2 << FRAC_BITS);
  localparam logic [OW-1:0] THREE_O = OW'(64'd3 << FRAC_BITS);
  localparam logic [OW-1:0] FOUR_O  = OW'(64'd4 << FRAC_BITS);
  localparam logic [PW-1:0] RND     = PW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [RW-1:0] ONE_R = RW'(64'd1 << FRAC_BITS);

  function automatic logic [OW-1:0] mulq(input logic [OW-1:0] a, input logic [OW-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b) + RND;
    return p[FRAC_BITS+OW-1:FRAC_BITS];
  endfunction

  logic [OW-1:0] tw, dw, u_in, a_in, b_in, m_in;

  assign tw = OW'(t);
  assign dw = OW'(d);

  always_comb begin
    case (ctl.func) inside
      FN_INOUTCUBIC, FN_INOUTQUINT: u_in = ctl.lo ? tw : dw;
      default: u_in = dw;
    endcase
    a_in = u_in;
    b_in = u_in;
    m_in = u_in;
    case (ctl.func)
      FN_SMOOTH: begin
        a_in = tw;
        b_in = tw;
        m_in = THREE_O - (tw << 1);
      end
      FN_INOUTQUAD: begin
        a_in = ctl.lo ? tw : FOUR_O - (tw << 1);
        b_in = tw;
      end
      FN_OUTQUAD: begin
        a_in = tw;
        b_in = TWO_O - tw;
      end
      default: ;
    endcase
  end

  logic [OW-1:0] p1, m1, u1;
  logic [OW-1:0] p2, p1_2, u2;
  logic [OW-1:0] p3, p1_3, p2_3, u3;
  logic [OW-1:0] p4, p1_4, p2_4;
  curve_ctrl_t   ctl1, ctl2, ctl3, ctl4;

  // One product per stage: u^2, u^3, u^4, u^5
  always_ff @(posedge clk) begin
    p1   <= mulq(a_in, b_in);
    m1   <= m_in;
    u1   <= u_in;
    ctl1 <= ctl;
    p2   <= mulq(p1, m1);
    p1_2 <= p1;
    u2   <= u1;
    ctl2 <= ctl1;
    p3   <= mulq(p2, u2);
    p1_3 <= p1_2;
    p2_3 <= p2;
    u3   <= u2;
    ctl3 <= ctl2;
    p4   <= mulq(p3, u3);
    p1_4 <= p1_3;
    p2_4 <= p2_3;
    ctl4 <= ctl3;
  end

  logic signed [RW-1:0] s1, s2, s4;

  assign s1 = $signed(RW'(p1_4));
  assign s2 = $signed(RW'(p2_4));
  assign s4 = $signed(RW'(p4));

  always_comb begin
    case (ctl4.func)
      FN_SMOOTH:     r = s2;
      FN_INOUTQUAD:  r = ctl4.lo ? (s1 <<< 1) : s1 - ONE_R;
      FN_INOUTCUBIC: r = ctl4.lo ? (s2 <<< 2) : ONE_R - (s2 <<< 2);
      FN_OUTCUBIC:   r = ONE_R - s2;
      FN_OUTQUINT:   r = ONE_R - s4;
      FN_OUTQUAD:    r = s1;
      FN_INOUTQUINT: r = ctl4.lo ? (s4 <<< 4) : ONE_R - (s4 <<< 4);
      default:       r = '0;
    endcase
  end

endmodule

[hdl/ecu_sine.sv]
`timescale 1ns / 1ps

module ecu_sine #(
  parameter int FRAC_BITS = 16,
  parameter int SINE_TABLE_LOG2 = 8
) (
  input  logic                 clk,
  input  ecu_pkg::curve_ctrl_t ctl,
  input  logic [FRAC_BITS:0]   t,
  input  logic [FRAC_BITS:0]   d,
  output logic [FRAC_BITS+1:0] r
);
  import ecu_pkg::*;

  localparam int N   = 1 << SINE_TABLE_LOG2;
  localparam int IW  = SINE_TABLE_LOG2 + 1;
  localparam int TW  = FRAC_BITS + 1;
  localparam int DW  = ENTRY_W + FRAC_BITS;
  localparam int VW  = ENTRY_W + 1;
  localparam int VW1 = VW + 1;
  localparam logic [IW-1:0]  LAST  = IW'(N);
  localparam logic [DW-1:0]  RND   = DW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [VW-1:0]  Q30_V = VW'(Q30);
  localparam logic [VW1-1:0] RND_V = VW1'(64'd1 << (30 - FRAC_BITS));

  typedef logic [ENTRY_W-1:0] cos_tab_t [0:N];

  function automatic cos_tab_t build_cos();
    cos_tab_t tab;
    logic [63:0] xi;
    int i;
    for (i = 0; i <= N; i++) begin
      xi = (HALF_PI_Q30 * 64'(i) + 64'(N / 2)) >> SINE_TABLE_LOG2;
      tab[i] = cos_series(xi);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos();

  // Fold the second half onto the first: cos(pi*t) = -cos(pi*(1-t))
  logic [TW-1:0]                 s;
  logic [TW+SINE_TABLE_LOG2:0]   pos;

  assign s   = ctl.le ? t : d;
  assign pos = {s, {IW{1'b0}}};

  logic [IW-1:0]          idx1, bidx;
  logic [FRAC_BITS-1:0]   fr1, fr2;
  logic                   neg1, neg2, neg3;
  logic [ENTRY_W-1:0]     a2, b2, a3, delta3, bb, diff, cq;
  logic [DW-1:0]          prod;
  logic [VW-1:0]          vq;
  logic [VW1-1:0]         rsum;

  assign bidx = (idx1 == LAST) ? idx1 : idx1 + 1'b1;
  assign bb   = (b2 > a2) ? a2 : b2;
  assign diff = a2 - bb;
  assign prod = DW'(diff) * DW'(fr2) + RND;
  assign cq   = a3 - delta3;
  assign vq   = neg3 ? Q30_V + VW'(cq) : Q30_V - VW'(cq);
  assign rsum = VW1'(vq) + RND_V;

  always_ff @(posedge clk) begin
    idx1   <= pos[FRAC_BITS+SINE_TABLE_LOG2:FRAC_BITS];
    fr1    <= pos[FRAC_BITS-1:0];
    neg1   <= ~ctl.le;
    a2     <= COS_TAB[idx1];
    b2     <= COS_TAB[bidx];
    fr2    <= fr1;
    neg2   <= neg1;
    delta3 <= prod[FRAC_BITS+ENTRY_W-1:FRAC_BITS];
    a3     <= a2;
    neg3   <= neg2;
    r      <= rsum[VW:31-FRAC_BITS];
  end

endmodule

[hdl/ecu_expo.sv]
`timescale 1ns / 1ps

module ecu_expo #(
  parameter int FRAC_BITS = 16,
  parameter int EXP_TABLE_LOG2 = 8
) (
  input  logic                 clk,
  input  ecu_pkg::curve_ctrl_t ctl,
  input  logic [FRAC_BITS:0]   t,
  output logic [FRAC_BITS+1:0] r
);
  import ecu_pkg::*;

  localparam int M   = 1 << EXP_TABLE_LOG2;
  localparam int EW  = FRAC_BITS + 5;
  localparam int DW  = ENTRY_W + FRAC_BITS;
  localparam int RW2 = FRAC_BITS + 2;
  localparam logic [EW-1:0]  NINE_E   = EW'(64'd9 << FRAC_BITS);
  localparam logic [EW-1:0]  ELEVEN_E = EW'(64'd11 << FRAC_BITS);
  localparam logic [DW-1:0]  RND      = DW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [RW2-1:0] ONE_R    = RW2'(64'd1 << FRAC_BITS);

  typedef logic [ENTRY_W-1:0] exp_tab_t [0:M];

  function automatic exp_tab_t build_exp();
    exp_tab_t tab;
    logic [63:0] yi;
    int i;
    for (i = 0; i <= M; i++) begin
      yi = (LN2_Q30 * 64'(i) + 64'(M / 2)) >> EXP_TABLE_LOG2;
      tab[i] = expneg_series(yi);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp();

  logic [EW-1:0]                     tw, t10, t20, e;
  logic [FRAC_BITS+EXP_TABLE_LOG2-1:0] fpos;

  assign tw   = EW'(t);
  assign t10  = (tw << 3) + (tw << 1);
  assign t20  = (tw << 4) + (tw << 2);
  assign e    = (ctl.func == FN_OUTEXPO) ? t10 :
                ctl.lo ? ELEVEN_E - t20 : t20 - NINE_E;
  assign fpos = {e[FRAC_BITS-1:0], {EXP_TABLE_LOG2{1'b0}}};

  logic [EXP_TABLE_LOG2-1:0] idx1;
  logic [EXP_TABLE_LOG2:0]   ai;
  logic [FRAC_BITS-1:0]      fr1, fr2;
  logic [3:0]                n1, n2, n3;
  curve_ctrl_t               ctl1, ctl2, ctl3, ctl4;
  logic [ENTRY_W-1:0]        a2, b2, a3, delta3, bb, diff, v;
  logic [DW-1:0]             prod;
  logic [RW2-1:0]            wv, ws, pe4;
  logic [RW2:0]              wr;

  assign ai   = {1'b0, idx1};
  assign bb   = (b2 > a2) ? a2 : b2;
  assign diff = a2 - bb;
  assign prod = DW'(diff) * DW'(fr2) + RND;
  assign v    = a3 - delta3;
  // Integer part of the exponent scales by a right shift; round half up
  assign wv   = RW2'(v >> (29 - FRAC_BITS));
  assign ws   = wv >> n3;
  assign wr   = {1'b0, ws} + 1'b1;

  always_ff @(posedge clk) begin
    idx1   <= fpos[FRAC_BITS+EXP_TABLE_LOG2-1:FRAC_BITS];
    fr1    <= fpos[FRAC_BITS-1:0];
    n1     <= e[FRAC_BITS+3:FRAC_BITS];
    ctl1   <= ctl;
    a2     <= EXP_TAB[ai];
    b2     <= EXP_TAB[ai + 1'b1];
    fr2    <= fr1;
    n2     <= n1;
    ctl2   <= ctl1;
    delta3 <= prod[FRAC_BITS+ENTRY_W-1:FRAC_BITS];
    a3     <= a2;
    n3     <= n2;
    ctl3   <= ctl2;
    pe4    <= wr[RW2:1];
    ctl4   <= ctl3;
  end

  // Exact endpoints override the table value; the out curve overrides only t = 1
  always_comb begin
    case (ctl4.func)
      FN_OUTEXPO: r = ctl4.t_one ? ONE_R : ONE_R - pe4;
      default: begin
        if (ctl4.t_zero) r = '0;
        else if (ctl4.t_one) r = ONE_R;
        else r = ctl4.lo ? pe4 : ONE_R - pe4;
      end
    endcase
  end

endmodule

[hdl/easing_curve_unit.sv]
// Easing curve unit: each request carries a curve selector (func) and a progress value in
// signed Q1.16 and yields one eased value in the same format. All curves but linear clamp
// progress to [0,1] first and saturate the rounded result to [0,1]; linear passes progress
// through unchanged, and unused selectors give zero. A request is taken whenever start is
// high and busy is low; busy never rises, so one request may be issued every clock cycle.
// Each result appears on eased with done high for exactly one cycle and must be captured
// then, as the unit cannot be held off. The pipeline depth is set by the quintic curves,
// whose four chained fixed-point products each take a pipeline stage, between an input
// register and an output register; the table lookups for sine and exponential curves are
// padded to the same depth, so results leave in request order.
`timescale 1ns / 1ps

module easing_curve_unit #(
  parameter int FRAC_BITS = 16,
  parameter int SINE_TABLE_LOG2 = 8,
  parameter int EXP_TABLE_LOG2 = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ecu_pkg::func_t  func,
  input  ecu_pkg::data_t  progress,
  output logic            done,
  output ecu_pkg::data_t  eased
);
  import ecu_pkg::*;

  localparam int TW = FRAC_BITS + 1;
  localparam int RW = FRAC_BITS + 8;
  localparam int CW = (TW > DATA_W - 1) ? TW : DATA_W - 1;
  localparam int SW = (RW > DATA_W + 1) ? RW : DATA_W + 1;
  localparam logic [TW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [TW-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [SW-1:0] ONE_S  = SW'(ONE);
  localparam logic signed [SW-1:0] FMAX_S = SW'(FIELD_MAX);
  localparam logic signed [SW-1:0] LIM    = (ONE_S < FMAX_S) ? ONE_S : FMAX_S;

  assign busy = 1'b0;

  // Clamp progress to [0, ONE]
  logic [CW-1:0] mag;
  logic [TW-1:0] t_in, d_in;
  curve_ctrl_t   ctl_in;

  assign mag = CW'(progress[DATA_W-2:0]);

  always_comb begin
    if (progress[DATA_W-1]) t_in = '0;
    else if (mag > CW'(ONE)) t_in = ONE;
    else t_in = TW'(mag);
  end

  assign d_in          = ONE - t_in;
  assign ctl_in.func   = func;
  assign ctl_in.lo     = (t_in < HALF);
  assign ctl_in.le     = (t_in <= HALF);
  assign ctl_in.t_zero = (t_in == '0);
  assign ctl_in.t_one  = (t_in == ONE);

  logic [4:0]    vld;
  logic [TW-1:0] t0, d0;
  curve_ctrl_t   ctl0;
  func_t         func_pipe [0:4];
  data_t         x_pipe [0:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    t0           <= t_in;
    d0           <= d_in;
    ctl0         <= ctl_in;
    func_pipe[0] <= func;
    x_pipe[0]    <= progress;
    for (int i = 1; i < 5; i++) begin
      func_pipe[i] <= func_pipe[i-1];
      x_pipe[i]    <= x_pipe[i-1];
    end
  end

  logic signed [RW-1:0] poly_r;
  logic [FRAC_BITS+1:0] sine_r, expo_r;

  ecu_poly #(
    .FRAC_BITS(FRAC_BITS)
  ) u_poly (
    .clk(clk),
    .ctl(ctl0),
    .t  (t0),
    .d  (d0),
    .r  (poly_r)
  );

  ecu_sine #(
    .FRAC_BITS      (FRAC_BITS),
    .SINE_TABLE_LOG2(SINE_TABLE_LOG2)
  ) u_sine (
    .clk(clk),
    .ctl(ctl0),
    .t  (t0),
    .d  (d0),
    .r  (sine_r)
  );

  ecu_expo #(
    .FRAC_BITS     (FRAC_BITS),
    .EXP_TABLE_LOG2(EXP_TABLE_LOG2)
  ) u_expo (
    .clk(clk),
    .ctl(ctl0),
    .t  (t0),
    .r  (expo_r)
  );

  logic signed [SW-1:0] r_sel, r_fin;
  logic                 sat;

  always_comb begin
    sat = 1'b1;
    case (func_pipe[4]) inside
      FN_SMOOTH, FN_INOUTQUAD, FN_INOUTCUBIC, FN_OUTCUBIC, FN_OUTQUINT, FN_OUTQUAD,
      FN_INOUTQUINT: r_sel = SW'(poly_r);
      FN_INOUTSINE: r_sel = SW'(sine_r);
      FN_OUTEXPO, FN_INOUTEXPO: r_sel = SW'(expo_r);
      FN_LINEAR: begin
        r_sel = SW'(x_pipe[4]);
        sat   = 1'b0;
      end
      default: r_sel = '0;
    endcase
    if (!sat) r_fin = r_sel;
    else if (r_sel < 0) r_fin = '0;
    else if (r_sel > LIM) r_fin = LIM;
    else r_fin = r_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    eased <= r_fin[DATA_W-1:0];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("accepted request did not complete after six edges");

  a_nonneg: assert property (@(posedge clk) disable iff (rst)
    (done && ($past(func_pipe[4]) != FN_LINEAR)) |-> !eased[DATA_W-1])
    else $error("saturated curve produced a negative value");

  a_linear: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FN_LINEAR) |-> ##6 (done && eased == $past(progress, 6)))
    else $error("linear curve did not pass progress through");

endmodule
